// File: hdl/label_border_color_highlight_assert.svh
// ---------------------------------------------------------------------------
// label border colour highlight - assertion macros
// concurrent checks clocked on clk_i and held off while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef LABEL_BORDER_COLOR_HIGHLIGHT_ASSERT_SVH
`define LABEL_BORDER_COLOR_HIGHLIGHT_ASSERT_SVH

// same-cycle implication
`define LBCH_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lbch check failed");

// next-cycle implication
`define LBCH_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lbch check failed");

`endif

// File: hdl/lbch_pkg.sv
// ---------------------------------------------------------------------------
// lbch_pkg
// shared types and constants of the label border colour highlight block
// ---------------------------------------------------------------------------
package lbch_pkg;

  // signed coordinate width: image side up to 1023 plus a window offset
  localparam int COORD_W    = 12;
  localparam int RGB_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_ENABLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_RED    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_GREEN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_BLUE   = 3'd6;

  typedef struct packed {
    logic        opcode;
    logic [8:0]  pos_x;
    logic [8:0]  pos_y;
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
    logic [15:0] pixel_label;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       on_border;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;
  } cfg_item_t;

endpackage

// File: hdl/lbch_if.sv
// ---------------------------------------------------------------------------
// lbch channel interfaces
// valid/ready channels for input items, result items and register writes
// ---------------------------------------------------------------------------
interface lbch_in_if import lbch_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lbch_out_if import lbch_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lbch_cfg_if import lbch_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/lbch_ram.sv
// ---------------------------------------------------------------------------
// lbch_ram
// single-port synchronous RAM with a registered read, no reset on contents
// ---------------------------------------------------------------------------
module lbch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first port, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/label_border_color_highlight.sv
// ---------------------------------------------------------------------------
// label_border_color_highlight
// segment border overlay over a stored RGB image and its label map
// ---------------------------------------------------------------------------
// Usage
//   in_i  : load items (opcode load) store a pixel and its label at (x,y);
//           read items (opcode read) ask for the highlighted pixel at (x,y)
//   res_o : one result item per read, none per load
//   cfg_i : register writes, always ready; write only while the block is idle
// Window walk
//   a load is written in the centre state, after which the control returns to idle;
//   a read walks every offset of the window and ends early when a border is
//   found; a read outside the image skips the walk
//   the walk issues one label memory read per offset over the single port
//   of the label RAM; each compare falls in the cycle after its read
// Reset and stalls
//   reset returns the registers to their defaults and the control to idle;
//   the image memories keep no reset value; the user must read them only once
//   written, which the block does not enforce; a finished result waits in the
//   output register; the next item is taken meanwhile, its result held until free
// ---------------------------------------------------------------------------
module label_border_color_highlight import lbch_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_RADIUS = 4,
  parameter int LABEL_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lbch_cfg_if.sink     cfg_i,
  lbch_in_if.sink      in_i,
  lbch_out_if.source   res_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OFF_W = $clog2(MAX_RADIUS + 1) + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CENTER = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  localparam logic signed [OFF_W-1:0] OFF_LO = OFF_W'(-MAX_RADIUS);
  localparam logic signed [OFF_W-1:0] OFF_HI = OFF_W'(MAX_RADIUS);

  // blend: floor((3*c + 7*p + 5) / 10) by reciprocal multiply
  function automatic logic [7:0] blend(input logic [7:0] c, input logic [7:0] p);
    logic [11:0] sum;
    logic [28:0] prod;
    sum  = 12'(12'd3 * 12'(c)) + 12'(12'd7 * 12'(p)) + 12'd5;
    prod = 29'(sum) * 29'(52429);
    return prod[26:19];
  endfunction

  // configuration registers
  logic [9:0] image_width_q, image_height_q;
  logic [4:0] radius_sq_q;
  logic       fill_enable_q;
  logic [7:0] color_red_q, color_green_q, color_blue_q;

  // control and payload registers
  logic [2:0]              state_q, state_d;
  in_item_t                item_q;
  logic signed [OFF_W-1:0] dx_q, dx_d, dy_q, dy_d;
  logic                    chk_q, chk_d;
  logic                    cap_q, cap_d;
  logic                    border_q, border_d;
  logic                    outside_q, outside_d;
  logic [LABEL_BITS-1:0]   lab_q;
  logic [RGB_W-1:0]        pix_q;
  logic                    res_valid_q, res_valid_d;
  out_item_t               res_q, res_d;

  // memory port
  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [COORD_W-2:0]    addr_x, addr_y;
  logic [RGB_W-1:0]      col_rdata;
  logic [LABEL_BITS-1:0] lab_rdata;

  // window arithmetic
  logic [9:0]                eff_w, eff_h;
  logic signed [COORD_W-1:0] w_s, h_s, x_s, y_s, dxs, dys, vx, vy, dist_sq, rsq_s;
  logic                      in_mem, outside, nb_ok, last_off;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= 10'd512;
      image_height_q <= 10'd512;
      radius_sq_q    <= 5'd2;
      fill_enable_q  <= 1'b0;
      color_red_q    <= 8'd255;
      color_green_q  <= 8'd0;
      color_blue_q   <= 8'd0;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.reg_index)
        REG_IMAGE_WIDTH:  image_width_q  <= cfg_i.data.reg_data[9:0];
        REG_IMAGE_HEIGHT: image_height_q <= cfg_i.data.reg_data[9:0];
        REG_RADIUS_SQ:    radius_sq_q    <= cfg_i.data.reg_data[4:0];
        REG_FILL_ENABLE:  fill_enable_q  <= cfg_i.data.reg_data[0];
        REG_COLOR_RED:    color_red_q    <= cfg_i.data.reg_data[7:0];
        REG_COLOR_GREEN:  color_green_q  <= cfg_i.data.reg_data[7:0];
        REG_COLOR_BLUE:   color_blue_q   <= cfg_i.data.reg_data[7:0];
        default: ;
      endcase
    end
  end

  // effective image size and window position
  assign eff_w = (32'(image_width_q) > MAX_WIDTH) ? 10'(MAX_WIDTH) : image_width_q;
  assign eff_h = (32'(image_height_q) > MAX_HEIGHT) ? 10'(MAX_HEIGHT) : image_height_q;
  assign w_s   = COORD_W'(eff_w);
  assign h_s   = COORD_W'(eff_h);
  assign x_s   = COORD_W'(item_q.pos_x);
  assign y_s   = COORD_W'(item_q.pos_y);
  assign dxs   = COORD_W'(dx_q);
  assign dys   = COORD_W'(dy_q);
  assign rsq_s = COORD_W'(radius_sq_q);
  assign vx    = x_s + dxs;
  assign vy    = y_s + dys;
  assign dist_sq = dxs * dxs + dys * dys;

  assign in_mem  = (32'(item_q.pos_x) < MAX_WIDTH) && (32'(item_q.pos_y) < MAX_HEIGHT);
  assign outside = (x_s >= w_s) || (y_s >= h_s);
  assign nb_ok   = !((dx_q == '0) && (dy_q == '0)) && (dist_sq <= rsq_s) &&
                   (vx >= 0) && (vy >= 0) && (vx < w_s) && (vy < h_s);
  assign last_off = (dx_q == OFF_HI) && (dy_q == OFF_HI);

  // address: row-major with a fixed pitch of MAX_WIDTH
  assign addr_x   = (state_q == S_SCAN) ? vx[COORD_W-2:0] : x_s[COORD_W-2:0];
  assign addr_y   = (state_q == S_SCAN) ? vy[COORD_W-2:0] : y_s[COORD_W-2:0];
  assign ram_addr = AW'(32'(addr_y) * MAX_WIDTH + 32'(addr_x));
  assign ram_we   = (state_q == S_CENTER) && (item_q.opcode == OP_LOAD) && in_mem;

  lbch_ram #(.WIDTH(RGB_W), .DEPTH(DEPTH)) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({item_q.pixel_red, item_q.pixel_green, item_q.pixel_blue}),
    .rdata_o (col_rdata)
  );

  lbch_ram #(.WIDTH(LABEL_BITS), .DEPTH(DEPTH)) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (LABEL_BITS'(item_q.pixel_label)),
    .rdata_o (lab_rdata)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    chk_d       = 1'b0;
    cap_d       = 1'b0;
    outside_d   = outside_q;
    border_d    = border_q;
    res_valid_d = res_valid_q && !res_o.ready;
    res_d       = res_q;

    // neighbour compare, in the cycle after its read
    if (chk_q && (lab_q > lab_rdata)) begin
      border_d = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_CENTER;
        end
      end
      S_CENTER: begin
        border_d = 1'b0;
        dx_d     = OFF_LO;
        dy_d     = OFF_LO;
        if (item_q.opcode == OP_LOAD) begin
          state_d = S_IDLE;
        end else if (outside) begin
          outside_d = 1'b1;
          state_d   = S_DONE;
        end else begin
          outside_d = 1'b0;
          cap_d     = 1'b1;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        chk_d = nb_ok;
        if (border_q) begin
          chk_d   = 1'b0;
          state_d = S_DONE;
        end else if (last_off) begin
          state_d = S_DRAIN;
        end else if (dx_q == OFF_HI) begin
          dx_d = OFF_LO;
          dy_d = dy_q + 1'b1;
        end else begin
          dx_d = dx_q + 1'b1;
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!res_valid_q || res_o.ready) begin
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (outside_q) begin
            res_d = '0;
          end else if (border_q) begin
            res_d = '{color_red_q, color_green_q, color_blue_q, 1'b1};
          end else if (fill_enable_q && (lab_q != '0)) begin
            res_d = '{blend(color_red_q, pix_q[23:16]), blend(color_green_q, pix_q[15:8]),
                      blend(color_blue_q, pix_q[7:0]), 1'b0};
          end else begin
            res_d = '{pix_q[23:16], pix_q[15:8], pix_q[7:0], 1'b0};
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dx_q        <= '0;
      dy_q        <= '0;
      chk_q       <= 1'b0;
      cap_q       <= 1'b0;
      border_q    <= 1'b0;
      outside_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dx_q        <= dx_d;
      dy_q        <= dy_d;
      chk_q       <= chk_d;
      cap_q       <= cap_d;
      border_q    <= border_d;
      outside_q   <= outside_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= in_i.data;
    end
    if (cap_q) begin
      lab_q <= lab_rdata;
      pix_q <= col_rdata;
    end
    res_q <= res_d;
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  // check helpers
  logic load_slot, done_blocked, res_is_colour;

  assign load_slot     = (state_q == S_CENTER) && (item_q.opcode == OP_LOAD);
  assign done_blocked  = (state_q == S_DONE) && res_valid_q && !res_o.ready;
  assign res_is_colour = (res_q.out_red == color_red_q) && (res_q.out_green == color_green_q) &&
                         (res_q.out_blue == color_blue_q);

  // checks
  `include "label_border_color_highlight_assert.svh"

  `LBCH_ASSERT_NOW(a_write_only_on_load, ram_we, load_slot)
  `LBCH_ASSERT_NEXT(a_border_clear_on_start, state_q == S_CENTER, !border_q)
  `LBCH_ASSERT_NEXT(a_done_holds_when_full, done_blocked, state_q == S_DONE)
  `LBCH_ASSERT_NOW(a_border_colour, res_valid_q && res_q.on_border, res_is_colour)

endmodule
